### hdl/spr_pkg.sv
package spr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COORD_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CENTER_W  = 12;
    localparam int PIX_W     = 14;
    localparam int COLOR_W   = 8;
    localparam int MARK_W    = 2;

    // Widths of the intermediate results.
    localparam int PROD_W  = 2 * COORD_W;
    localparam int XR_W    = PROD_W + 1 - FRAC_BITS;
    localparam int ZP_W    = XR_W + COORD_W;
    localparam int TSUM_W  = ZP_W + 1;
    localparam int YT_W    = TSUM_W - FRAC_BITS;
    localparam int ZT_W    = FRAC_BITS + 2;
    localparam int RAD_W   = CENTER_W + 1;
    localparam int PXP_W   = XR_W + RAD_W;
    localparam int PYP_W   = YT_W + RAD_W;
    localparam int PROJ_W  = PYP_W + 1;
    localparam int BPROD_W = FRAC_BITS + 10;

    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam int PIX_MAX   = (1 << (PIX_W - 1)) - 1;
    localparam int PIX_MIN   = -(1 << (PIX_W - 1));
    localparam int BLUE_BASE = 40;
    localparam int BLUE_SPAN = 150;

    localparam logic [MARK_W-1:0]  MARK_FRONT = 2'd2;
    localparam logic [MARK_W-1:0]  MARK_BACK  = 2'd1;
    localparam logic [COLOR_W-1:0] LAND_FRONT_R = 8'd90;
    localparam logic [COLOR_W-1:0] LAND_FRONT_G = 8'd200;
    localparam logic [COLOR_W-1:0] LAND_FRONT_B = 8'd110;
    localparam logic [COLOR_W-1:0] LAND_BACK_R  = 8'd30;
    localparam logic [COLOR_W-1:0] LAND_BACK_G  = 8'd80;
    localparam logic [COLOR_W-1:0] LAND_BACK_B  = 8'd45;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_SPIN = 3'd0,
        CFG_SIN_SPIN = 3'd1,
        CFG_COS_TILT = 3'd2,
        CFG_SIN_TILT = 3'd3,
        CFG_CENTER_X = 3'd4,
        CFG_CENTER_Y = 3'd5,
        CFG_RADIUS   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] cos_spin;
        logic signed [COORD_W-1:0] sin_spin;
        logic signed [COORD_W-1:0] cos_tilt;
        logic signed [COORD_W-1:0] sin_tilt;
        logic [CENTER_W-1:0]       center_x;
        logic [CENTER_W-1:0]       center_y;
        logic [CENTER_W-1:0]       radius_px;
    } t_cfg;

    typedef struct packed {
        logic signed [XR_W-1:0] xr;
        logic signed [YT_W-1:0] yt;
        logic signed [ZT_W-1:0] zt;
        logic                   land;
    } t_rot;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic [MARK_W-1:0]       marker_size;
        logic [COLOR_W-1:0]      red;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      blue;
    } t_result;

endpackage

### hdl/spr_cfg.sv
module spr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spr_pkg::COORD_W-1:0]   i_cfg_data,
    output spr_pkg::t_cfg                 o_cfg
);
    import spr_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_spin  <= 16'sd16384;
            r_cfg.sin_spin  <= 16'sd0;
            r_cfg.cos_tilt  <= 16'sd15009;
            r_cfg.sin_tilt  <= 16'sd6577;
            r_cfg.center_x  <= 12'd320;
            r_cfg.center_y  <= 12'd240;
            r_cfg.radius_px <= 12'd100;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COS_SPIN: r_cfg.cos_spin  <= i_cfg_data;
                CFG_SIN_SPIN: r_cfg.sin_spin  <= i_cfg_data;
                CFG_COS_TILT: r_cfg.cos_tilt  <= i_cfg_data;
                CFG_SIN_TILT: r_cfg.sin_tilt  <= i_cfg_data;
                CFG_CENTER_X: r_cfg.center_x  <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_cfg.center_y  <= i_cfg_data[CENTER_W-1:0];
                CFG_RADIUS:   r_cfg.radius_px <= i_cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### hdl/spr_rotate.sv
module spr_rotate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spr_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [spr_pkg::COORD_W-1:0] i_x,
    input  logic signed [spr_pkg::COORD_W-1:0] i_y,
    input  logic signed [spr_pkg::COORD_W-1:0] i_z,
    input  logic                        i_land,
    output logic                        o_valid,
    input  logic                        i_ready,
    output spr_pkg::t_rot               o_rot
);
    import spr_pkg::*;

    localparam logic signed [YT_W-1:0] ZT_HI = YT_W'(ONE_Q);
    localparam logic signed [YT_W-1:0] ZT_LO = YT_W'(-ONE_Q);

    logic r1_v, r2_v, r3_v, r4_v;
    logic en1, en2, en3, en4;

    // Stage 1: spin products.
    logic signed [PROD_W-1:0]  r1_xc, r1_zs, r1_zc, r1_xs;
    logic signed [COORD_W-1:0] r1_y;
    logic                      r1_land;
    // Stage 2: spun x and z.
    logic signed [XR_W-1:0]    r2_xr, r2_zr;
    logic signed [COORD_W-1:0] r2_y;
    logic                      r2_land;
    // Stage 3: tilt products.
    logic signed [PROD_W-1:0]  r3_yct, r3_yst;
    logic signed [ZP_W-1:0]    r3_zst, r3_zct;
    logic signed [XR_W-1:0]    r3_xr;
    logic                      r3_land;
    // Stage 4: tilted y and saturated z.
    t_rot                      r4_rot;

    logic signed [PROD_W:0]    s_xr, s_zr;
    logic signed [TSUM_W-1:0]  s_yt, s_zt;
    logic signed [YT_W-1:0]    zt_full;
    logic signed [ZT_W-1:0]    n_zt;

    assign en4 = !r4_v || i_ready;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;

    assign o_ready = en1;
    assign o_valid = r4_v;
    assign o_rot   = r4_rot;

    // Taking the upper bits of the sums floors toward minus infinity.
    assign s_xr = (PROD_W+1)'(r1_xc) + (PROD_W+1)'(r1_zs);
    assign s_zr = (PROD_W+1)'(r1_zc) - (PROD_W+1)'(r1_xs);
    assign s_yt = TSUM_W'(r3_yct) - TSUM_W'(r3_zst);
    assign s_zt = TSUM_W'(r3_yst) + TSUM_W'(r3_zct);
    assign zt_full = s_zt[TSUM_W-1:FRAC_BITS];

    always_comb begin
        if (zt_full > ZT_HI) begin
            n_zt = ZT_HI[ZT_W-1:0];
        end else if (zt_full < ZT_LO) begin
            n_zt = ZT_LO[ZT_W-1:0];
        end else begin
            n_zt = zt_full[ZT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_xc   <= i_x * $signed(i_cfg.cos_spin);
            r1_zs   <= i_z * $signed(i_cfg.sin_spin);
            r1_zc   <= i_z * $signed(i_cfg.cos_spin);
            r1_xs   <= i_x * $signed(i_cfg.sin_spin);
            r1_y    <= i_y;
            r1_land <= i_land;
        end
        if (en2) begin
            r2_xr   <= s_xr[PROD_W:FRAC_BITS];
            r2_zr   <= s_zr[PROD_W:FRAC_BITS];
            r2_y    <= r1_y;
            r2_land <= r1_land;
        end
        if (en3) begin
            r3_yct  <= r2_y * $signed(i_cfg.cos_tilt);
            r3_yst  <= r2_y * $signed(i_cfg.sin_tilt);
            r3_zst  <= r2_zr * $signed(i_cfg.sin_tilt);
            r3_zct  <= r2_zr * $signed(i_cfg.cos_tilt);
            r3_xr   <= r2_xr;
            r3_land <= r2_land;
        end
        if (en4) begin
            r4_rot.xr   <= r3_xr;
            r4_rot.yt   <= s_yt[TSUM_W-1:FRAC_BITS];
            r4_rot.zt   <= n_zt;
            r4_rot.land <= r3_land;
        end
    end

endmodule

### hdl/spr_shade.sv
module spr_shade (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spr_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  spr_pkg::t_rot    i_rot,
    output logic             o_valid,
    input  logic             i_ready,
    output spr_pkg::t_result o_res
);
    import spr_pkg::*;

    localparam logic signed [YT_W-1:0] Q_MAX = YT_W'(PIX_MAX);
    localparam logic signed [YT_W-1:0] Q_MIN = YT_W'(PIX_MIN);

    logic r5_v, r6_v, r7_v;
    logic en5, en6, en7;

    logic signed [PXP_W-1:0]  r5_px_prod;
    logic signed [PYP_W-1:0]  r5_py_prod;
    logic [MARK_W-1:0]        r5_mark, r6_mark;
    logic [COLOR_W-1:0]       r5_red, r5_green, r5_blue;
    logic [COLOR_W-1:0]       r6_red, r6_green, r6_blue;
    logic signed [PROJ_W-1:0] r6_sx, r6_sy;
    t_result                  r7_res;

    logic signed [RAD_W-1:0]  radius_s;
    logic                     front;
    logic [ZT_W:0]            zoff;
    logic [BPROD_W-1:0]       bprod;
    logic [COLOR_W-1:0]       grid_blue;
    logic [COLOR_W-1:0]       n_red, n_green, n_blue;
    logic signed [PROJ_W-1:0] cx_q, cy_q;

    function automatic logic signed [PIX_W-1:0] proj_pix(input logic signed [PROJ_W-1:0] s);
        logic signed [PROJ_W-1:0] adj;
        logic signed [YT_W-1:0]   q;
        // Rounds toward zero: negative sums get the fraction mask added first.
        adj = s + (s[PROJ_W-1] ? PROJ_W'(ONE_Q - 1) : PROJ_W'(0));
        q   = adj[PROJ_W-1:FRAC_BITS];
        if (q > Q_MAX) begin
            return Q_MAX[PIX_W-1:0];
        end else if (q < Q_MIN) begin
            return Q_MIN[PIX_W-1:0];
        end
        return q[PIX_W-1:0];
    endfunction

    assign en7 = !r7_v || i_ready;
    assign en6 = !r6_v || en7;
    assign en5 = !r5_v || en6;

    assign o_ready = en5;
    assign o_valid = r7_v;
    assign o_res   = r7_res;

    assign radius_s = $signed({1'b0, i_cfg.radius_px});
    assign front    = !i_rot.zt[ZT_W-1];

    // Depth shading: zt + 1 lies in [0, 2], scaled by the blue span over two.
    assign zoff      = (ZT_W+1)'(i_rot.zt) + (ZT_W+1)'(ONE_Q);
    assign bprod     = BPROD_W'(zoff[ZT_W-1:0]) * BPROD_W'(BLUE_SPAN);
    assign grid_blue = COLOR_W'(BLUE_BASE) + COLOR_W'(bprod[BPROD_W-1:FRAC_BITS+1]);

    always_comb begin
        if (i_rot.land) begin
            n_red   = front ? LAND_FRONT_R : LAND_BACK_R;
            n_green = front ? LAND_FRONT_G : LAND_BACK_G;
            n_blue  = front ? LAND_FRONT_B : LAND_BACK_B;
        end else begin
            n_red   = grid_blue >> 1;
            n_green = grid_blue >> 1;
            n_blue  = grid_blue;
        end
    end

    assign cx_q = $signed({{(PROJ_W-CENTER_W-FRAC_BITS){1'b0}}, i_cfg.center_x,
                           {FRAC_BITS{1'b0}}});
    assign cy_q = $signed({{(PROJ_W-CENTER_W-FRAC_BITS){1'b0}}, i_cfg.center_y,
                           {FRAC_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            if (en5) r5_v <= i_valid;
            if (en6) r6_v <= r5_v;
            if (en7) r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_px_prod <= i_rot.xr * radius_s;
            r5_py_prod <= i_rot.yt * radius_s;
            r5_mark    <= front ? MARK_FRONT : MARK_BACK;
            r5_red     <= n_red;
            r5_green   <= n_green;
            r5_blue    <= n_blue;
        end
        if (en6) begin
            r6_sx    <= cx_q + PROJ_W'(r5_px_prod);
            r6_sy    <= cy_q + PROJ_W'(r5_py_prod);
            r6_mark  <= r5_mark;
            r6_red   <= r5_red;
            r6_green <= r5_green;
            r6_blue  <= r5_blue;
        end
        if (en7) begin
            r7_res.pixel_x     <= proj_pix(r6_sx);
            r7_res.pixel_y     <= proj_pix(r6_sy);
            r7_res.marker_size <= r6_mark;
            r7_res.red         <= r6_red;
            r7_res.green       <= r6_green;
            r7_res.blue        <= r6_blue;
        end
    end

endmodule

### hdl/sphere_point_rotate_project_shade.sv
// Rotates a unit-sphere point about the spin axis and then the tilt axis, projects it
// orthographically to screen pixels and picks a marker size and color. The block takes
// one item per clock unless back-pressure stalls it; each accepted item passes through four
// stages for the spin and tilt multiplies and their sums, one stage of radius multiplies,
// and one each for the center add and the rounding and clamping into the output
// register. Every stage holds its own valid bit, so back-pressure on the result side
// only stops the input once all seven stages are full. The seven registers are written
// over the cfg channel, which is always ready; write them only while no item is in flight.
module sphere_point_rotate_project_shade (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // point_x [15:0], point_y [31:16], point_z [47:32]
    input  logic [47:0] i_s_axis_tdata,
    // is_land [0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_x [13:0], pixel_y [27:14], marker_size [29:28], red [37:30],
    // green [45:38], blue [53:46], zero [55:54]
    output logic [55:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spr_pkg::COORD_W-1:0]   i_cfg_data
);
    import spr_pkg::*;

    t_cfg    cfg;
    t_rot    rot;
    t_result res;
    logic    rot_valid, rot_ready;

    spr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    spr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_x     ($signed(i_s_axis_tdata[15:0])),
        .i_y     ($signed(i_s_axis_tdata[31:16])),
        .i_z     ($signed(i_s_axis_tdata[47:32])),
        .i_land  (i_s_axis_tuser),
        .o_valid (rot_valid),
        .i_ready (rot_ready),
        .o_rot   (rot)
    );

    spr_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (rot_valid),
        .o_ready (rot_ready),
        .i_rot   (rot),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {2'b00, res.blue, res.green, res.red, res.marker_size,
                             res.pixel_y, res.pixel_x};

endmodule
